// ===== sv/dlsar_pkg.sv =====
// ----------------------------------------------------------------------------
// dlsar_pkg
// Shared types and constants for the dual-line serial converter reader.
// ----------------------------------------------------------------------------
package dlsar_pkg;

    localparam int DEFAULT_SAMPLE_BITS = 16;
    localparam int WORD_W              = 16;
    localparam int TICK_W              = 16;
    localparam int SHORT_W             = 12;
    localparam int CFG_IDX_W           = 3;
    localparam int CFG_DATA_W          = 16;
    localparam int IN_TDATA_W          = 8;
    localparam int OUT_TDATA_W         = 40;

    localparam logic [TICK_W-1:0] WARMUP_HALF_TICKS = 16'd20;

    localparam logic [SHORT_W-1:0] RST_CLOCK_HIGH   = 12'd96;
    localparam logic [SHORT_W-1:0] RST_LOW_BEFORE   = 12'd29;
    localparam logic [SHORT_W-1:0] RST_AFTER_SAMPLE = 12'd63;
    localparam logic [SHORT_W-1:0] RST_LAST_GAP     = 12'd144;
    localparam logic [SHORT_W-1:0] RST_START_PULSE  = 12'd20;
    localparam logic [SHORT_W-1:0] RST_AFTER_PULSE  = 12'd473;
    localparam logic [SHORT_W-1:0] RST_WARMUP       = 12'd1024;
    localparam logic [TICK_W-1:0]  RST_SETTLE       = 16'd2000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CLOCK_HIGH   = 3'd0,
        REG_LOW_BEFORE   = 3'd1,
        REG_AFTER_SAMPLE = 3'd2,
        REG_LAST_GAP     = 3'd3,
        REG_START_PULSE  = 3'd4,
        REG_AFTER_PULSE  = 3'd5,
        REG_WARMUP       = 3'd6,
        REG_SETTLE       = 3'd7
    } t_reg_idx;

    typedef enum logic [7:0] {
        PH_WARM_HI      = 8'b0000_0001,
        PH_WARM_LO      = 8'b0000_0010,
        PH_SETTLE       = 8'b0000_0100,
        PH_START        = 8'b0000_1000,
        PH_AFTER_PULSE  = 8'b0001_0000,
        PH_CLK_HI       = 8'b0010_0000,
        PH_LOW_WAIT     = 8'b0100_0000,
        PH_AFTER_SAMPLE = 8'b1000_0000
    } t_phase;

    function automatic logic [SHORT_W-1:0] at_least_one(input logic [SHORT_W-1:0] v);
        at_least_one = (v == '0) ? SHORT_W'(1) : v;
    endfunction

endpackage

// ===== sv/dual_line_serial_adc_reader.sv =====
// ----------------------------------------------------------------------------
// dual_line_serial_adc_reader
// Serial master for a converter with two data lines: warmup clocks, settle
// wait, then endless frames of start pulse and clocked two-line capture.
// ----------------------------------------------------------------------------
// One input beat is one tick of pin timing; the block takes one beat per
// clock and returns exactly one output beat for it in the next cycle through
// an output register. The tick timing (phase, tick and bit counters, shift
// registers) advances in a single pass per accepted beat, so throughput is one
// beat per cycle whenever the output side is ready. Each output beat carries
// the select and serial clock levels for that tick; on the first tick of every
// start pulse it also flags and carries the two words captured in the previous
// frame (zero for the first frame). Timing registers are written through the
// configuration channel, which is always ready.
module dual_line_serial_adc_reader #(
    parameter int SAMPLE_BITS = dlsar_pkg::DEFAULT_SAMPLE_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dlsar_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dlsar_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [0] data_a, [1] data_b, [7:2] zero
    input  logic [dlsar_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] chip_select, [1] serial_clock, [2] word_valid,
    // [18:3] channel_a, [34:19] channel_b, [39:35] zero
    output logic [dlsar_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import dlsar_pkg::*;

    localparam int BIT_W = $clog2(SAMPLE_BITS + 1);
    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(SAMPLE_BITS);

    logic [SHORT_W-1:0] r_clock_high, r_low_before, r_after_sample, r_last_gap;
    logic [SHORT_W-1:0] r_start_pulse, r_after_pulse, r_warmup;
    logic [TICK_W-1:0]  r_settle;

    t_phase             r_phase, n_phase;
    logic [TICK_W-1:0]  r_tick, n_tick;
    logic [BIT_W-1:0]   r_bit, n_bit;
    logic [SHORT_W-1:0] r_warm_cnt, n_warm_cnt;
    logic [WORD_W-1:0]  r_shift_a, n_shift_a, r_shift_b, n_shift_b;

    logic               r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    t_phase             ph_eff;
    logic [TICK_W-1:0]  tick_eff, tick_inc, phase_len;
    logic               cs, sclk, wvalid;
    logic [WORD_W-1:0]  word_a, word_b;
    logic               accept;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_high   <= RST_CLOCK_HIGH;
            r_low_before   <= RST_LOW_BEFORE;
            r_after_sample <= RST_AFTER_SAMPLE;
            r_last_gap     <= RST_LAST_GAP;
            r_start_pulse  <= RST_START_PULSE;
            r_after_pulse  <= RST_AFTER_PULSE;
            r_warmup       <= RST_WARMUP;
            r_settle       <= RST_SETTLE;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_CLOCK_HIGH:   r_clock_high   <= i_cfg_data[SHORT_W-1:0];
                REG_LOW_BEFORE:   r_low_before   <= i_cfg_data[SHORT_W-1:0];
                REG_AFTER_SAMPLE: r_after_sample <= i_cfg_data[SHORT_W-1:0];
                REG_LAST_GAP:     r_last_gap     <= i_cfg_data[SHORT_W-1:0];
                REG_START_PULSE:  r_start_pulse  <= i_cfg_data[SHORT_W-1:0];
                REG_AFTER_PULSE:  r_after_pulse  <= i_cfg_data[SHORT_W-1:0];
                REG_WARMUP:       r_warmup       <= i_cfg_data[SHORT_W-1:0];
                REG_SETTLE:       r_settle       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // entry skips, tick action, then interval end check
    always_comb begin
        ph_eff   = r_phase;
        tick_eff = r_tick;
        if (ph_eff == PH_WARM_HI && r_warm_cnt >= r_warmup) begin
            ph_eff   = PH_SETTLE;
            tick_eff = '0;
        end
        if (ph_eff == PH_SETTLE && tick_eff >= r_settle) begin
            ph_eff   = PH_START;
            tick_eff = '0;
        end

        cs         = 1'b0;
        sclk       = 1'b0;
        wvalid     = 1'b0;
        word_a     = '0;
        word_b     = '0;
        n_shift_a  = r_shift_a;
        n_shift_b  = r_shift_b;
        n_bit      = r_bit;
        n_warm_cnt = r_warm_cnt;

        case (ph_eff)
            PH_WARM_HI, PH_CLK_HI: begin
                sclk = 1'b1;
            end
            PH_START: begin
                cs = 1'b1;
                if (tick_eff == '0) begin
                    wvalid    = 1'b1;
                    word_a    = r_shift_a;
                    word_b    = r_shift_b;
                    n_shift_a = '0;
                    n_shift_b = '0;
                    n_bit     = '0;
                end
            end
            PH_AFTER_SAMPLE: begin
                if (tick_eff == '0) begin
                    n_shift_a = {r_shift_a[WORD_W-2:0], s_axis_tdata[0]};
                    n_shift_b = {r_shift_b[WORD_W-2:0], s_axis_tdata[1]};
                    if (r_bit < LAST_BIT) begin
                        n_bit = r_bit + BIT_W'(1);
                    end
                end
            end
            default: ;
        endcase

        case (ph_eff)
            PH_WARM_HI, PH_WARM_LO: phase_len = WARMUP_HALF_TICKS;
            PH_SETTLE:              phase_len = r_settle;
            PH_START:               phase_len = TICK_W'(at_least_one(r_start_pulse));
            PH_AFTER_PULSE:         phase_len = TICK_W'(at_least_one(r_after_pulse));
            PH_CLK_HI:              phase_len = TICK_W'(at_least_one(r_clock_high));
            PH_LOW_WAIT:            phase_len = TICK_W'(at_least_one(r_low_before));
            default: begin
                if (n_bit >= LAST_BIT) begin
                    phase_len = TICK_W'(at_least_one(r_last_gap));
                end else begin
                    phase_len = TICK_W'(at_least_one(r_after_sample));
                end
            end
        endcase

        tick_inc = tick_eff + TICK_W'(1);
        n_tick   = tick_inc;
        n_phase  = ph_eff;
        if (tick_inc >= phase_len) begin
            n_tick = '0;
            case (ph_eff)
                PH_WARM_HI:     n_phase = PH_WARM_LO;
                PH_WARM_LO: begin
                    n_warm_cnt = r_warm_cnt + SHORT_W'(1);
                    n_phase    = PH_WARM_HI;
                end
                PH_SETTLE:      n_phase = PH_START;
                PH_START:       n_phase = PH_AFTER_PULSE;
                PH_AFTER_PULSE: n_phase = PH_CLK_HI;
                PH_CLK_HI:      n_phase = PH_LOW_WAIT;
                PH_LOW_WAIT:    n_phase = PH_AFTER_SAMPLE;
                default: begin
                    if (n_bit >= LAST_BIT) begin
                        n_bit   = '0;
                        n_phase = PH_START;
                    end else begin
                        n_phase = PH_CLK_HI;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_WARM_HI;
            r_tick     <= '0;
            r_bit      <= '0;
            r_warm_cnt <= '0;
            r_shift_a  <= '0;
            r_shift_b  <= '0;
        end else if (accept) begin
            r_phase    <= n_phase;
            r_tick     <= n_tick;
            r_bit      <= n_bit;
            r_warm_cnt <= n_warm_cnt;
            r_shift_a  <= n_shift_a;
            r_shift_b  <= n_shift_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= {5'd0, word_b, word_a, wvalid, sclk, cs};
        end
    end

    a_word_in_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data[2] |-> r_out_data[0] && !r_out_data[1])
        else $error("word beat outside start pulse");

    a_quiet_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_data[2] |-> r_out_data[34:3] == '0)
        else $error("nonzero words without word flag");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit <= LAST_BIT)
        else $error("bit counter out of range");

    a_start_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && r_phase == PH_START && r_tick == '0 |=> r_out_valid && r_out_data[2])
        else $error("start of pulse gave no word beat");

    a_cleared_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && wvalid |=> r_shift_a == '0 && r_shift_b == '0 && r_bit == '0)
        else $error("shift state not cleared at word beat");

endmodule
